/* hw/rtl/hpt_pkg.sv */
`default_nettype none

package hpt_pkg;

  // Fixed field widths
  localparam int ADDR_BITS   = 50;
  localparam int MODE_BITS   = 3;
  localparam int STATUS_BITS = 2;
  localparam int TAG_BITS    = 48;
  localparam int LINE_BITS   = TAG_BITS + 1;  // valid flag on top of the tag

  // Entry bit positions touched by the modify modes
  localparam int WRITE_BIT_POS    = 2;
  localparam int ACCESSED_BIT_POS = 6;

  // Request modes
  localparam logic [MODE_BITS-1:0] MODE_LOOKUP    = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_SET       = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_CLEAR     = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_WRPROT    = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_TEST_CLR  = 3'd4;
  localparam logic [MODE_BITS-1:0] MODE_TEST      = 3'd5;

  // Result status codes
  localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd2;

  // Sequencer states
  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_TAG   = 5'b00100,
    S_ENTRY = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

endpackage

`default_nettype wire

/* hw/rtl/hashed_page_table_engine.sv */
// Flow: the home line's tag is read on input transfer, and lines are probed in turn until a
//   hit, an empty line or the last of LINES lines; the result is then registered.
// Throughput: one request at a time; each probe is one tag RAM read, and a hit (or a set
//   into an empty line) ends with one entry RAM read-modify-write.
// Reset: a clearing sweep over all LINES*SLOTS_PER_LINE entries zeroes both RAMs,
//   with in_stall high until it ends.
`default_nettype none

module hashed_page_table_engine #(
  parameter int LINES          = 256,  // power of two
  parameter int SLOTS_PER_LINE = 8,    // power of two
  parameter int ENTRY_BITS     = 56,
  parameter int BLOCK_SHIFT    = 17
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [hpt_pkg::MODE_BITS-1:0]   mode,
  input  wire logic [hpt_pkg::ADDR_BITS-1:0]   guest_address,
  input  wire logic [ENTRY_BITS-1:0]           new_entry,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [hpt_pkg::STATUS_BITS-1:0] status,
  output logic      [ENTRY_BITS-1:0]           entry_value,
  output logic                                 accessed_flag
);

  import hpt_pkg::*;

  localparam int LB         = $clog2(LINES);
  localparam int SB         = $clog2(SLOTS_PER_LINE);
  localparam int DEPTH      = LINES * SLOTS_PER_LINE;
  localparam int EB         = LB + SB;
  localparam int BLOCK_BITS = ADDR_BITS - BLOCK_SHIFT;
  localparam int SLOT_LSB   = BLOCK_SHIFT - 3;

  state_t state;

  // Request registers
  logic [MODE_BITS-1:0]  cur_mode;
  logic [BLOCK_BITS-1:0] cur_block;
  logic [SB-1:0]         cur_slot;
  logic [ENTRY_BITS-1:0] cur_entry;
  logic [LB-1:0]         line;
  logic [LB-1:0]         probes;
  logic                  is_miss;
  logic [EB-1:0]         clr_idx;

  // Pending result
  logic [STATUS_BITS-1:0] res_status;
  logic [ENTRY_BITS-1:0]  res_value;
  logic                   res_flag;

  // RAM ports
  logic                  tag_we;
  logic [LB-1:0]         tag_wr_addr;
  logic [LINE_BITS-1:0]  tag_wr_data;
  logic [LB-1:0]         tag_rd_addr;
  logic [LINE_BITS-1:0]  tag_rd_data;
  logic                  ent_we;
  logic [EB-1:0]         ent_wr_addr;
  logic [ENTRY_BITS-1:0] ent_wr_data;
  logic [EB-1:0]         ent_rd_addr;
  logic [ENTRY_BITS-1:0] ent_rd_data;

  logic                  in_xfer;
  logic                  out_free;
  logic [BLOCK_BITS-1:0] in_block;
  logic [TAG_BITS-1:0]   cur_tag;
  logic                  tag_hit;
  logic                  tag_miss;
  logic                  last_probe;
  logic [ENTRY_BITS-1:0] old_wp;
  logic [ENTRY_BITS-1:0] old_ta;
  logic                  mod_we;
  logic [ENTRY_BITS-1:0] mod_data;

  assign in_stall   = (state != S_IDLE);
  assign in_xfer    = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign in_block   = guest_address[ADDR_BITS-1:BLOCK_SHIFT];
  assign cur_tag    = {{(TAG_BITS-BLOCK_BITS){1'b0}}, cur_block};
  assign tag_miss   = !tag_rd_data[TAG_BITS];
  assign tag_hit    = tag_rd_data[TAG_BITS] && (tag_rd_data[TAG_BITS-1:0] == cur_tag);
  assign last_probe = (probes == LB'(LINES - 1));

  // Tag read: home line on transfer, next line while walking
  always_comb begin
    if (state == S_IDLE) begin
      tag_rd_addr = in_block[LB-1:0];
    end else begin
      tag_rd_addr = line + LB'(1);
    end
  end

  assign ent_rd_addr = {line, cur_slot};

  // Modified entry for the modify modes
  always_comb begin
    old_wp = ent_rd_data;
    old_wp[WRITE_BIT_POS] = 1'b0;
    old_ta = ent_rd_data;
    old_ta[ACCESSED_BIT_POS] = 1'b0;
    mod_we   = 1'b0;
    mod_data = ent_rd_data;
    case (cur_mode)
      MODE_SET: begin
        mod_we   = 1'b1;
        mod_data = cur_entry;
      end
      MODE_CLEAR: begin
        mod_we   = !is_miss && (ent_rd_data != '0);
        mod_data = '0;
      end
      MODE_WRPROT: begin
        mod_we   = !is_miss && (ent_rd_data != '0);
        mod_data = old_wp;
      end
      MODE_TEST_CLR: begin
        mod_we   = !is_miss;
        mod_data = old_ta;
      end
      default: begin
        mod_we   = 1'b0;
        mod_data = ent_rd_data;
      end
    endcase
  end

  // Write ports: clearing sweep, else write-back in the entry state
  always_comb begin
    if (state == S_CLEAR) begin
      tag_we      = 1'b1;
      tag_wr_addr = clr_idx[EB-1:SB];
      tag_wr_data = '0;
      ent_we      = 1'b1;
      ent_wr_addr = clr_idx;
      ent_wr_data = '0;
    end else begin
      tag_we      = (state == S_ENTRY) && (cur_mode == MODE_SET) && is_miss;
      tag_wr_addr = line;
      tag_wr_data = {1'b1, cur_tag};
      ent_we      = (state == S_ENTRY) && mod_we;
      ent_wr_addr = {line, cur_slot};
      ent_wr_data = mod_data;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      // Raise the result when the output register is free, drop it once taken
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + EB'(1);
          if (clr_idx == EB'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            state <= S_TAG;
          end
        end
        S_TAG: begin
          if (tag_hit || tag_miss) begin
            if (tag_miss && (cur_mode != MODE_SET)) begin
              state <= S_DONE;
            end else begin
              state <= S_ENTRY;
            end
          end else if (last_probe) begin
            state <= S_DONE;
          end
        end
        S_ENTRY: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request, walk and result datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          cur_mode  <= mode;
          cur_block <= in_block;
          cur_slot  <= guest_address[SLOT_LSB +: SB];
          cur_entry <= new_entry;
          line      <= in_block[LB-1:0];
          probes    <= '0;
        end
      end
      S_TAG: begin
        is_miss <= tag_miss;
        if (tag_hit || tag_miss) begin
          res_status <= STATUS_NOT_FOUND;
          res_value  <= '0;
          res_flag   <= 1'b0;
        end else if (last_probe) begin
          res_status <= (cur_mode == MODE_SET) ? STATUS_FULL : STATUS_NOT_FOUND;
          res_value  <= '0;
          res_flag   <= 1'b0;
        end else begin
          line   <= line + LB'(1);
          probes <= probes + LB'(1);
        end
      end
      S_ENTRY: begin
        res_status <= STATUS_OK;
        res_value  <= ent_rd_data;
        res_flag   <= (cur_mode inside {MODE_TEST_CLR, MODE_TEST})
                      && ent_rd_data[ACCESSED_BIT_POS];
      end
      S_DONE: begin
        if (out_free) begin
          status        <= res_status;
          entry_value   <= res_value;
          accessed_flag <= res_flag;
        end
      end
      default: begin
      end
    endcase
  end

  hpt_ram #(
    .WIDTH(LINE_BITS),
    .DEPTH(LINES)
  ) u_tag_ram (
    .clk    (clk),
    .we     (tag_we),
    .wr_addr(tag_wr_addr),
    .wr_data(tag_wr_data),
    .rd_addr(tag_rd_addr),
    .rd_data(tag_rd_data)
  );

  hpt_ram #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(DEPTH)
  ) u_entry_ram (
    .clk    (clk),
    .we     (ent_we),
    .wr_addr(ent_wr_addr),
    .wr_data(ent_wr_data),
    .rd_addr(ent_rd_addr),
    .rd_data(ent_rd_data)
  );

endmodule

`default_nettype wire

/* hw/rtl/hpt_ram.sv */
`default_nettype none

module hpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire
